// ----- hw/rtl/dtc_pkg.sv -----
`timescale 1ns / 1ps

package dtc_pkg;

  // Width of a request mode and a trouble code.
  localparam int unsigned ModeW = 3;
  localparam int unsigned CodeW = 24;

  // Request modes.
  localparam logic [ModeW-1:0] MODE_TEST_RESULT = 3'd0;
  localparam logic [ModeW-1:0] MODE_CLEAR_ONE   = 3'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR_ALL   = 3'd2;
  localparam logic [ModeW-1:0] MODE_REPORT_MASK = 3'd3;
  localparam logic [ModeW-1:0] MODE_REPORT_SUPP = 3'd4;

  // Result codes.
  localparam logic [1:0] RC_OK    = 2'd0;
  localparam logic [1:0] RC_MISS  = 2'd1;
  localparam logic [1:0] RC_FULL  = 2'd2;
  localparam logic [1:0] RC_EMPTY = 2'd3;

  // Status byte values and bits.
  localparam logic [7:0] STAT_NEW       = 8'h07;
  localparam logic [7:0] STAT_FAIL_BITS = 8'h03;
  localparam logic [7:0] STAT_FAILED    = 8'h01;
  localparam logic [7:0] STAT_CONFIRMED = 8'h08;
  localparam logic [7:0] STAT_CLEARED   = 8'h10;

  localparam logic [7:0] COUNT_MAX     = 8'hFF;
  localparam logic [7:0] CONFIRM_RESET = 8'd3;

  // Results given for one report at most, and the width of their counter.
  localparam int unsigned MaxResults = 16;
  localparam int unsigned TakenW     = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [7:0]       status;
    logic [1:0]       wheel;
    logic [7:0]       count;
  } entry_t;

  typedef struct packed {
    logic             occ;
    entry_t           entry;
  } tbl_rd_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CodeW-1:0] dtc_number;
    logic             test_failed;
    logic [1:0]       wheel;
    logic [7:0]       status_mask;
  } dtc_req_t;

  typedef struct packed {
    logic [1:0]       result_code;
    logic [CodeW-1:0] entry_code;
    logic [7:0]       entry_status;
    logic [1:0]       entry_wheel;
    logic [7:0]       entry_count;
    logic             last;
  } dtc_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

endpackage

// ----- hw/rtl/diagnostic_trouble_code_table.sv -----
`timescale 1ns / 1ps
// A new request is taken only in the idle state, once the final result of the last
// one has entered the output register. The sweep reads one table slot per cycle
// through a single port; it stalls while a report result must wait for the output
// register, and the request stretches by that stall.
// Reset: the table is empty (per-slot valid bits clear at once), the threshold
// returns to 3, and no result is pending.

module diagnostic_trouble_code_table import dtc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dtc_req_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dtc_rsp_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  // One index bit at least, so that a single-slot table still elaborates.
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // The confirm threshold is written directly; the user must change it only while the
  // block is idle (the block does not enforce this), as the sequencer has no shadow copy.
  logic [7:0] confirm_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_threshold_q <= CONFIRM_RESET;
    end else if (cfg_we_i) begin
      confirm_threshold_q <= cfg_wdata_i;
    end
  end

  logic            rd_en;
  logic [IdxW-1:0] rd_idx;
  tbl_rd_t         rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_entry;

  // The sequencer sweeps every slot once per request. For test results and
  // clear-one it notes the first slot holding the code and the first empty
  // slot, then writes the updated entry in a final step. Clear-all rewrites
  // occupied slots during the sweep itself. Reports pass matching entries
  // out in slot order, one result per transfer, and stall the sweep while
  // the output register is still occupied.
  dtc_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IdxW)
  ) u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .in_data_i           (in_data_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_data_o          (out_data_o),
    .confirm_threshold_i (confirm_threshold_q),
    .rd_en_o             (rd_en),
    .rd_idx_o            (rd_idx),
    .rd_data_i           (rd_data),
    .wr_en_o             (wr_en),
    .wr_idx_o            (wr_idx),
    .wr_entry_o          (wr_entry)
  );

  // Slot storage: one read and one write port, registered read data.
  dtc_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_idx_i   (rd_idx),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry)
  );

endmodule

// ----- hw/rtl/dtc_table.sv -----
`timescale 1ns / 1ps

module dtc_table import dtc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output tbl_rd_t          rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  entry_t           wr_entry_i
);

  // Entry storage. Every slot that is written becomes occupied, so a slot's
  // valid bit doubles as its occupied flag.
  entry_t                 mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  entry_t                 rd_entry_q;
  logic                   rd_occ_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_occ_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_occ_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o.occ   = rd_occ_q;
  assign rd_data_o.entry = rd_occ_q ? rd_entry_q : '0;

endmodule

// ----- hw/rtl/dtc_seq.sv -----
`timescale 1ns / 1ps

module dtc_seq import dtc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dtc_req_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dtc_rsp_t         out_data_o,
  input  logic [7:0]       confirm_threshold_i,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_idx_o,
  input  tbl_rd_t          rd_data_i,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_idx_o,
  output entry_t           wr_entry_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_DEPTH - 1);

  state_e            state_q, state_d;
  dtc_req_t          req_q;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic              iss_done_q, iss_done_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic              hit_found_q, hit_found_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  entry_t            hit_ent_q, hit_ent_d;
  logic              free_found_q, free_found_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic              pend_vld_q, pend_vld_d;
  dtc_rsp_t          pend_q, pend_d;
  logic [TakenW-1:0] taken_q, taken_d;
  logic              out_vld_q, out_vld_d;
  dtc_rsp_t          out_q, out_d;

  logic      accept;
  logic      out_free;
  logic      is_report;
  logic      rpt_match;
  logic      stall;
  logic      chk_go;
  logic      scan_end;
  logic      fin_fire;
  logic      fin_wr;
  logic      clr_wr;
  dtc_rsp_t  rpt_rsp;
  dtc_rsp_t  fin_rsp;
  entry_t    fin_ent;
  logic [IDX_W-1:0] fin_idx;
  logic [7:0] inc_count;
  entry_t    clr_ent;

  assign out_free  = !out_vld_q || out_ready_i;
  assign is_report = (req_q.mode == MODE_REPORT_MASK) || (req_q.mode == MODE_REPORT_SUPP);

  // A report match is held in a pending register until the next one shows
  // up, so that the final result can be marked as last.
  assign rpt_match = chk_vld_q && rd_data_i.occ && is_report &&
                     ((req_q.mode == MODE_REPORT_SUPP) ||
                      ((rd_data_i.entry.status & req_q.status_mask) != 8'h00)) &&
                     (taken_q < TakenW'(MaxResults));
  assign stall    = rpt_match && pend_vld_q && !out_free;
  assign chk_go   = chk_vld_q && !stall;
  assign scan_end = (state_q == S_SCAN) && chk_go && (chk_idx_q == LastIdx);
  assign fin_fire = (state_q == S_FINISH) && out_free;

  assign rpt_rsp = '{result_code:  RC_OK,
                     entry_code:   rd_data_i.entry.code,
                     entry_status: rd_data_i.entry.status,
                     entry_wheel:  rd_data_i.entry.wheel,
                     entry_count:  rd_data_i.entry.count,
                     last:         1'b0};

  assign inc_count = (hit_ent_q.count != COUNT_MAX) ? hit_ent_q.count + 8'd1
                                                     : hit_ent_q.count;

  // Clear-all rewrites each occupied slot as the sweep passes it.
  assign clr_wr = (state_q == S_SCAN) && chk_vld_q && rd_data_i.occ &&
                  (req_q.mode == MODE_CLEAR_ALL);
  always_comb begin
    clr_ent        = rd_data_i.entry;
    clr_ent.status = STAT_CLEARED;
  end

  // Final action of an item, taken once the sweep is over.
  always_comb begin
    fin_rsp             = '0;
    fin_rsp.result_code = RC_MISS;
    fin_rsp.last        = 1'b1;
    fin_wr              = 1'b0;
    fin_idx             = hit_idx_q;
    fin_ent             = hit_ent_q;
    unique case (req_q.mode)
      MODE_TEST_RESULT: begin
        if (req_q.dtc_number != '0) begin
          if (hit_found_q) begin
            if (req_q.test_failed) begin
              fin_ent.status = hit_ent_q.status | STAT_FAIL_BITS;
              fin_ent.count  = inc_count;
              if (inc_count >= confirm_threshold_i) begin
                fin_ent.status = hit_ent_q.status | STAT_FAIL_BITS | STAT_CONFIRMED;
              end
            end else begin
              fin_ent.status = hit_ent_q.status & ~STAT_FAILED;
            end
            fin_wr              = 1'b1;
            fin_rsp.result_code = RC_OK;
          end else if (req_q.test_failed) begin
            if (free_found_q) begin
              fin_idx             = free_idx_q;
              fin_ent.code        = req_q.dtc_number;
              fin_ent.status      = STAT_NEW;
              fin_ent.wheel       = req_q.wheel;
              fin_ent.count       = 8'd1;
              fin_wr              = 1'b1;
              fin_rsp.result_code = RC_OK;
            end else begin
              fin_rsp.result_code = RC_FULL;
            end
          end
        end
      end
      MODE_CLEAR_ONE: begin
        if ((req_q.dtc_number != '0) && hit_found_q) begin
          fin_ent.status      = STAT_CLEARED;
          fin_wr              = 1'b1;
          fin_rsp.result_code = RC_OK;
        end
      end
      MODE_CLEAR_ALL: begin
        fin_rsp.result_code = RC_OK;
      end
      MODE_REPORT_MASK, MODE_REPORT_SUPP: begin
        if (pend_vld_q) begin
          fin_rsp      = pend_q;
          fin_rsp.last = 1'b1;
        end else begin
          fin_rsp.result_code = RC_EMPTY;
        end
      end
      default: begin
        fin_rsp.result_code = RC_MISS;
      end
    endcase
    if (fin_wr) begin
      fin_rsp.entry_code   = fin_ent.code;
      fin_rsp.entry_status = fin_ent.status;
      fin_rsp.entry_wheel  = fin_ent.wheel;
      fin_rsp.entry_count  = fin_ent.count;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SCAN;
      S_SCAN:   if (scan_end) state_d = S_FINISH;
      S_FINISH: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates.
  always_comb begin
    accept       = (state_q == S_IDLE) && in_valid_i;
    rd_en_o      = (state_q == S_SCAN) && !iss_done_q && !stall;
    rd_idx_o     = ptr_q;
    wr_en_o      = clr_wr || (fin_fire && fin_wr);
    wr_idx_o     = clr_wr ? chk_idx_q : fin_idx;
    wr_entry_o   = clr_wr ? clr_ent : fin_ent;

    ptr_d        = ptr_q;
    iss_done_d   = iss_done_q;
    chk_vld_d    = stall ? chk_vld_q : rd_en_o;
    chk_idx_d    = rd_en_o ? ptr_q : chk_idx_q;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    hit_ent_d    = hit_ent_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    taken_d      = taken_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_d        = out_q;

    if (accept) begin
      ptr_d        = '0;
      iss_done_d   = 1'b0;
      hit_found_d  = 1'b0;
      free_found_d = 1'b0;
      pend_vld_d   = 1'b0;
      taken_d      = '0;
    end

    if (rd_en_o) begin
      if (ptr_q == LastIdx) begin
        iss_done_d = 1'b1;
      end else begin
        ptr_d = ptr_q + IDX_W'(1);
      end
    end

    if ((state_q == S_SCAN) && chk_go) begin
      if (rd_data_i.occ && !hit_found_q &&
          (rd_data_i.entry.code == req_q.dtc_number)) begin
        hit_found_d = 1'b1;
        hit_idx_d   = chk_idx_q;
        hit_ent_d   = rd_data_i.entry;
      end
      if (!rd_data_i.occ && !free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = chk_idx_q;
      end
      if (rpt_match) begin
        taken_d    = taken_q + TakenW'(1);
        pend_vld_d = 1'b1;
        pend_d     = rpt_rsp;
        if (pend_vld_q) begin
          out_vld_d = 1'b1;
          out_d     = pend_q;
        end
      end
    end

    if (fin_fire) begin
      out_vld_d  = 1'b1;
      out_d      = fin_rsp;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      iss_done_q   <= 1'b0;
      chk_vld_q    <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      pend_vld_q   <= 1'b0;
      taken_q      <= '0;
      out_vld_q    <= 1'b0;
      ptr_q        <= '0;
    end else begin
      state_q      <= state_d;
      iss_done_q   <= iss_done_d;
      chk_vld_q    <= chk_vld_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      pend_vld_q   <= pend_vld_d;
      taken_q      <= taken_d;
      out_vld_q    <= out_vld_d;
      ptr_q        <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    chk_idx_q  <= chk_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_ent_q  <= hit_ent_d;
    free_idx_q <= free_idx_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/tb_diagnostic_trouble_code_table.sv -----
`timescale 1ns / 1ps

// This bench drives requests into the trouble code table and checks every result
// against a behavioral copy of the fault memory that is kept inside the bench.
// The copy is updated at each request transfer. The results that it predicts wait in a
// queue and are matched in order against the result transfers.
module tb_diagnostic_trouble_code_table;
  import dtc_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 300;
  // Longer than the sweep that one request takes, so the block has gone quiet.
  localparam int unsigned SettleCycles = 2 * (Depth + 2);

  localparam logic [CodeW-1:0] CODE_NONE = '0;
  localparam logic [CodeW-1:0] CODE_TOP  = '1;
  localparam logic [CodeW-1:0] CODE_LOW  = 24'h000001;
  localparam logic [CodeW-1:0] CODE_HIGH = 24'h800000;
  localparam logic [CodeW-1:0] CODE_ODD  = 24'h123456;

  // Mode values that the block does not implement. They must answer with a miss.
  localparam logic [ModeW-1:0] MODE_UNUSED_5 = 3'd5;
  localparam logic [ModeW-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_UNUSED_7 = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  dtc_req_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  dtc_rsp_t   out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  diagnostic_trouble_code_table #(
    .TABLE_DEPTH(Depth)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // The bench keeps its own copy of the fault memory and of the confirm threshold.
  logic [CodeW-1:0] mem_code   [Depth];
  logic [7:0]       mem_status [Depth];
  logic [1:0]       mem_wheel  [Depth];
  logic [7:0]       mem_count  [Depth];
  logic [7:0]       mem_threshold = CONFIRM_RESET;

  dtc_req_t         pending_req_q[$];
  dtc_rsp_t         expected_rsp_q[$];
  logic [CodeW-1:0] code_pool[$];

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 76;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_added = 0;
  int unsigned n_full = 0;
  int unsigned n_rows = 0;
  logic [7:0]  thr_random;

  initial begin
    for (int i = 0; i < Depth; i++) begin
      mem_code[i]   = '0;
      mem_status[i] = '0;
      mem_wheel[i]  = '0;
      mem_count[i]  = '0;
    end
  end

  // Returns the slot that holds the given code, or -1. Because an empty slot holds
  // code zero, a search for zero finds the lowest free slot.
  function automatic int slot_of(logic [CodeW-1:0] code);
    for (int i = 0; i < Depth; i++) begin
      if (mem_code[i] == code) return i;
    end
    return -1;
  endfunction

  // Queues one expected result. A slot of -1 means that the entry fields are zero.
  function automatic void expect_row(logic [1:0] rc, int slot, logic fin);
    dtc_rsp_t row;
    row = '0;
    row.result_code = rc;
    if (slot >= 0) begin
      row.entry_code   = mem_code[slot];
      row.entry_status = mem_status[slot];
      row.entry_wheel  = mem_wheel[slot];
      row.entry_count  = mem_count[slot];
    end
    row.last = fin;
    expected_rsp_q.push_back(row);
  endfunction

  // Reports list the occupied slots in slot order, filtered by the mask when one is
  // used. A report with no match gives a single "report empty" answer.
  function automatic void expect_report(logic use_mask, logic [7:0] mask);
    int hits[$];
    for (int i = 0; i < Depth && hits.size() < MaxResults; i++) begin
      if (mem_code[i] != CODE_NONE && (!use_mask || (mem_status[i] & mask) != '0)) begin
        hits.push_back(i);
      end
    end
    if (hits.size() == 0) begin
      expect_row(RC_EMPTY, -1, 1'b1);
    end else begin
      foreach (hits[k]) expect_row(RC_OK, hits[k], k == hits.size() - 1);
      n_rows += hits.size();
    end
  endfunction

  // Applies one accepted request to the copy of the memory and queues its results.
  function automatic void apply_request(dtc_req_t req);
    int slot;
    slot = slot_of(req.dtc_number);
    case (req.mode)
      MODE_TEST_RESULT: begin
        if (req.dtc_number == CODE_NONE) begin
          expect_row(RC_MISS, -1, 1'b1);
        end else if (slot >= 0) begin
          if (req.test_failed) begin
            mem_status[slot] |= STAT_FAIL_BITS;
            if (mem_count[slot] != COUNT_MAX) mem_count[slot]++;
            // A threshold of zero confirms on every update.
            if (mem_count[slot] >= mem_threshold) mem_status[slot] |= STAT_CONFIRMED;
          end else begin
            mem_status[slot] &= ~STAT_FAILED;
          end
          expect_row(RC_OK, slot, 1'b1);
        end else if (!req.test_failed) begin
          expect_row(RC_MISS, -1, 1'b1);
        end else begin
          slot = slot_of(CODE_NONE);
          if (slot < 0) begin
            n_full++;
            expect_row(RC_FULL, -1, 1'b1);
          end else begin
            mem_code[slot]   = req.dtc_number;
            mem_wheel[slot]  = req.wheel;
            mem_status[slot] = STAT_NEW;
            mem_count[slot]  = 8'd1;
            n_added++;
            expect_row(RC_OK, slot, 1'b1);
          end
        end
      end
      MODE_CLEAR_ONE: begin
        if (req.dtc_number == CODE_NONE || slot < 0) begin
          expect_row(RC_MISS, -1, 1'b1);
        end else begin
          mem_status[slot] = STAT_CLEARED;
          expect_row(RC_OK, slot, 1'b1);
        end
      end
      MODE_CLEAR_ALL: begin
        for (int i = 0; i < Depth; i++) begin
          if (mem_code[i] != CODE_NONE) mem_status[i] = STAT_CLEARED;
        end
        expect_row(RC_OK, -1, 1'b1);
      end
      MODE_REPORT_MASK: expect_report(1'b1, req.status_mask);
      MODE_REPORT_SUPP: expect_report(1'b0, '0);
      default: expect_row(RC_MISS, -1, 1'b1);
    endcase
  endfunction

  function automatic void queue_request(logic [ModeW-1:0] mode, logic [CodeW-1:0] code,
                                        logic failed, logic [1:0] wheel, logic [7:0] mask);
    dtc_req_t req;
    req.mode        = mode;
    req.dtc_number  = code;
    req.test_failed = failed;
    req.wheel       = wheel;
    req.status_mask = mask;
    pending_req_q.push_back(req);
  endfunction

  // Most codes come from the pool of codes that have already been reported as failing,
  // so that updates, passes and clears find their entries. The rest are fresh codes.
  function automatic logic [CodeW-1:0] pick_code(int unsigned known_pct);
    logic [CodeW-1:0] code;
    if (code_pool.size() != 0 && $urandom_range(99) < known_pct) begin
      code = code_pool[$urandom_range(code_pool.size() - 1)];
    end else begin
      code = CodeW'($urandom_range(CODE_TOP, 1));
    end
    return code;
  endfunction

  // Builds one random request. Fields that the chosen mode ignores keep their
  // random values.
  function automatic dtc_req_t random_request();
    dtc_req_t    req;
    int unsigned pick;
    req.mode        = MODE_TEST_RESULT;
    req.dtc_number  = CodeW'($urandom());
    req.test_failed = 1'($urandom_range(1));
    req.wheel       = 2'($urandom_range(3));
    req.status_mask = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 40) begin
      req.test_failed = 1'b1;
      req.dtc_number  = pick_code(70);
      // The pool may grow slightly past the table size, so that table-full answers occur.
      if (code_pool.size() < Depth + 8) code_pool.push_back(req.dtc_number);
    end else if (pick < 55) begin
      req.test_failed = 1'b0;
      req.dtc_number  = pick_code(80);
    end else if (pick < 67) begin
      req.mode       = MODE_CLEAR_ONE;
      req.dtc_number = pick_code(80);
    end else if (pick < 72) begin
      req.mode = MODE_CLEAR_ALL;
    end else if (pick < 86) begin
      req.mode = MODE_REPORT_MASK;
    end else if (pick < 93) begin
      req.mode = MODE_REPORT_SUPP;
    end else if (pick < 96) begin
      req.mode       = ($urandom_range(1) != 0) ? MODE_CLEAR_ONE : MODE_TEST_RESULT;
      req.dtc_number = CODE_NONE;
    end else begin
      req.mode = ModeW'($urandom_range(MODE_UNUSED_7, MODE_UNUSED_5));
    end
    return req;
  endfunction

  function automatic void queue_random(int unsigned count);
    repeat (count) pending_req_q.push_back(random_request());
  endfunction

  // The sender presents a new request only after the previous one has been taken.
  // The request is predicted at the clock edge on which its transfer happens.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(in_data);
        n_requests++;
      end
      if (!in_valid || in_ready) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver stalls at random. When a hold is requested, it also refuses every
  // result for a long stretch, which it counts itself.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready   <= 1'b0;
      hold_left   <= HoldCycles;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each result transfer is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    dtc_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_rsp_q.size() == 0) begin
        $error("Result with no request outstanding: %p", out_data);
        err_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_data.result_code !== want.result_code) begin
          $error("result_code: expected %0d, got %0d", want.result_code, out_data.result_code);
          err_count++;
        end
        if (out_data.entry_code !== want.entry_code) begin
          $error("entry_code: expected %06h, got %06h", want.entry_code, out_data.entry_code);
          err_count++;
        end
        if (out_data.entry_status !== want.entry_status) begin
          $error("entry_status: expected %02h, got %02h", want.entry_status,
                 out_data.entry_status);
          err_count++;
        end
        if (out_data.entry_wheel !== want.entry_wheel) begin
          $error("entry_wheel: expected %0d, got %0d", want.entry_wheel, out_data.entry_wheel);
          err_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_data.entry_count);
          err_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          err_count++;
        end
      end
    end
  end

  // Watchdog for a block that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Waits until every queued request has been taken and every result has arrived.
  task automatic wait_drained();
    while (pending_req_q.size() != 0 || in_valid || expected_rsp_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the threshold while the block is quiet. The copy follows after the edge
  // at which the write takes effect.
  task automatic write_threshold(logic [7:0] value);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mem_threshold = value;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset threshold of three. First, the empty-table answers
    // and the rejection of code zero and of a pass for an unknown code.
    queue_request(MODE_REPORT_SUPP, CODE_NONE, 1'b0, 2'd0, 8'h00);
    queue_request(MODE_REPORT_MASK, CODE_TOP, 1'b1, 2'd3, 8'hFF);
    queue_request(MODE_CLEAR_ALL, CODE_NONE, 1'b0, 2'd0, 8'h00);
    queue_request(MODE_TEST_RESULT, CODE_NONE, 1'b1, 2'd1, 8'h00);
    queue_request(MODE_CLEAR_ONE, CODE_NONE, 1'b0, 2'd0, 8'h00);
    queue_request(MODE_TEST_RESULT, CODE_ODD, 1'b0, 2'd2, 8'h00);
    // New entries on three of the wheels, then updates until one entry is confirmed.
    queue_request(MODE_TEST_RESULT, CODE_TOP, 1'b1, 2'd3, 8'h00);
    queue_request(MODE_TEST_RESULT, CODE_LOW, 1'b1, 2'd0, 8'hFF);
    queue_request(MODE_TEST_RESULT, CODE_HIGH, 1'b1, 2'd2, 8'h00);
    queue_request(MODE_TEST_RESULT, CODE_TOP, 1'b1, 2'd0, 8'h00);
    queue_request(MODE_TEST_RESULT, CODE_TOP, 1'b1, 2'd1, 8'h00);
    queue_request(MODE_TEST_RESULT, CODE_TOP, 1'b0, 2'd0, 8'h00);
    // One clear, a clear of an unknown code, masked reports, unused modes and a clear-all.
    queue_request(MODE_CLEAR_ONE, CODE_LOW, 1'b0, 2'd0, 8'h00);
    queue_request(MODE_CLEAR_ONE, CODE_ODD, 1'b0, 2'd0, 8'h00);
    queue_request(MODE_REPORT_MASK, CODE_NONE, 1'b0, 2'd0, 8'h08);
    queue_request(MODE_REPORT_MASK, CODE_NONE, 1'b0, 2'd0, 8'h00);
    queue_request(MODE_REPORT_MASK, CODE_NONE, 1'b0, 2'd0, 8'h10);
    queue_request(MODE_UNUSED_5, CODE_TOP, 1'b1, 2'd3, 8'hFF);
    queue_request(MODE_UNUSED_6, CODE_LOW, 1'b0, 2'd0, 8'h00);
    queue_request(MODE_UNUSED_7, CODE_HIGH, 1'b1, 2'd1, 8'h55);
    queue_request(MODE_CLEAR_ALL, CODE_NONE, 1'b0, 2'd0, 8'h00);
    queue_request(MODE_REPORT_SUPP, CODE_NONE, 1'b0, 2'd0, 8'h00);
    queue_request(MODE_TEST_RESULT, CODE_LOW, 1'b1, 2'd3, 8'h00);
    queue_request(MODE_REPORT_MASK, CODE_NONE, 1'b0, 2'd0, 8'hFF);
    code_pool = '{CODE_TOP, CODE_LOW, CODE_HIGH};

    // The sender idles rarely and the receiver often. In the middle of this stretch
    // the sender pauses until every result has arrived.
    write_threshold(8'd1);
    queue_random(35);
    wait_drained();
    queue_random(35);

    // The sender idles often and the receiver rarely. The receiver holds off for a
    // long stretch while requests keep coming, so the block must stall its input.
    write_threshold(8'd0);
    send_idle_pct = 76;
    recv_idle_pct = 19;
    queue_random(35);
    hold_requests++;

    // Neither side idles. One code is cleared and then reported as failing until its
    // count saturates. At the top threshold it is confirmed when the count saturates.
    write_threshold(COUNT_MAX);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_request(MODE_CLEAR_ONE, CODE_TOP, 1'b0, 2'd0, 8'h00);
    repeat (Depth * Depth + 4) begin
      queue_request(MODE_TEST_RESULT, CODE_TOP, 1'b1, 2'($urandom_range(3)),
                    8'($urandom_range(255)));
    end
    queue_request(MODE_REPORT_MASK, CODE_NONE, 1'b0, 2'd0, STAT_CONFIRMED);

    thr_random = 8'($urandom_range(254, 2));
    write_threshold(thr_random);
    queue_random(30);

    wait_drained();
    repeat (SettleCycles) @(posedge clk);

    $display("Checked %0d results of %0d requests: %0d entries added,", n_results,
             n_requests, n_added);
    $display("%0d table-full answers and %0d report rows.", n_full, n_rows);
    $display("Thresholds 3, 1, 0, 255 and %0d were used, with one count driven to saturation.",
             thr_random);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dtc_pkg.sv
hw/rtl/dtc_table.sv
hw/rtl/dtc_seq.sv
hw/rtl/diagnostic_trouble_code_table.sv
tb/tb_diagnostic_trouble_code_table.sv
